[hdl/vbh_pkg.sv]
// shared widths, pipeline depths and the arctangent table of the vertex heading core
package vbh_pkg;

    localparam int CoordW   = 24;
    localparam int DiffW    = CoordW + 1;
    localparam int SqW      = 2 * DiffW - 1;
    localparam int RadW     = 64;
    localparam int RootW    = 32;
    localparam int NumW     = 48;
    localparam int QuoW     = 18;
    localparam int UnitW    = 18;
    localparam int SumW     = UnitW + 1;
    localparam int CordW    = 29;
    localparam int AccW     = 32;
    localparam int AngleW   = 16;

    localparam int CORDIC_STAGES = 16;
    localparam int CordicN   = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
    localparam int SqrtSteps = RootW;
    localparam int DivSteps  = QuoW;
    localparam int LaneLat   = 2 + SqrtSteps + 1 + DivSteps + 1;

    localparam logic [QuoW-1:0] UnitOne  = QuoW'(65536);
    localparam logic [AccW-1:0] HalfTurn = 32'h8000_0000;
    localparam logic [AccW-1:0] RoundAdd = 32'h0000_8000;

    // sign and zero flags of one difference vector
    typedef struct packed {
        logic neg_x;
        logic neg_z;
        logic zero;
    } vbh_flags_t;

    function automatic logic [AccW-1:0] atan_entry(input int idx);
        logic [AccW-1:0] val;
        case (idx)
            0:  val = 32'h20000000;
            1:  val = 32'h12E4051E;
            2:  val = 32'h09FB385B;
            3:  val = 32'h051111D4;
            4:  val = 32'h028B0D43;
            5:  val = 32'h0145D7E1;
            6:  val = 32'h00A2F61E;
            7:  val = 32'h00517C55;
            8:  val = 32'h0028BE53;
            9:  val = 32'h00145F2F;
            10: val = 32'h000A2F98;
            11: val = 32'h000517CC;
            12: val = 32'h00028BE6;
            13: val = 32'h000145F3;
            14: val = 32'h0000A2FA;
            15: val = 32'h0000517D;
            16: val = 32'h000028BE;
            17: val = 32'h0000145F;
            18: val = 32'h00000A30;
            19: val = 32'h00000518;
            20: val = 32'h0000028C;
            21: val = 32'h00000146;
            22: val = 32'h000000A3;
            23: val = 32'h00000051;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

[hdl/vertex_bisector_heading_core.sv]
// vertex bisector heading core: two normalizing lanes feeding a pipelined cordic
// request path: difference registers, both normalizing lanes, cordic stages, output register
// throughput: one request per cycle; the whole pipeline stalls only while a result
// sits in the output register and m_ready is low
// reset: synchronous active-low aresetn clears all valid bits; payload is not reset
module vertex_bisector_heading_core
    import vbh_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [CoordW-1:0] s_prev_x,
    input  logic signed [CoordW-1:0] s_prev_z,
    input  logic signed [CoordW-1:0] s_vertex_x,
    input  logic signed [CoordW-1:0] s_vertex_z,
    input  logic signed [CoordW-1:0] s_next_x,
    input  logic signed [CoordW-1:0] s_next_z,
    input  logic                     s_has_successor,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [AngleW-1:0]        m_heading_angle
);

    // global advance: every stage moves when the output slot frees up
    logic en;
    logic m_valid_reg;
    logic [AngleW-1:0] m_heading_reg;

    assign en      = m_ready || !m_valid_reg;
    assign s_ready = en;

    // difference stage: outgoing (next - vertex) and incoming (vertex - prev)
    logic                    d_valid_reg;
    logic signed [DiffW-1:0] d_out_x_reg, d_out_z_reg, d_in_x_reg, d_in_z_reg;
    logic                    d_succ_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (en) begin
            d_valid_reg <= s_valid;
        end
        if (en) begin
            d_out_x_reg <= DiffW'(s_next_x) - DiffW'(s_vertex_x);
            d_out_z_reg <= DiffW'(s_next_z) - DiffW'(s_vertex_z);
            d_in_x_reg  <= DiffW'(s_vertex_x) - DiffW'(s_prev_x);
            d_in_z_reg  <= DiffW'(s_vertex_z) - DiffW'(s_prev_z);
            d_succ_reg  <= s_has_successor;
        end
    end

    // unit vectors of both directions, computed side by side
    logic                    ua_valid, ub_valid;
    logic signed [UnitW-1:0] ua_x, ua_z, ub_x, ub_z;

    vbh_unit u_lane_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_valid_reg),
        .dx        (d_out_x_reg),
        .dz        (d_out_z_reg),
        .out_valid (ua_valid),
        .ux        (ua_x),
        .uz        (ua_z)
    );

    vbh_unit u_lane_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_valid_reg),
        .dx        (d_in_x_reg),
        .dz        (d_in_z_reg),
        .out_valid (ub_valid),
        .ux        (ub_x),
        .uz        (ub_z)
    );

    // successor flag rides alongside the lanes and the cordic
    localparam int SuccLat = LaneLat + CordicN + 1;
    logic succ_line_reg [0:SuccLat-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            succ_line_reg[0] <= d_succ_reg;
            for (int i = 1; i < SuccLat; i++) begin
                succ_line_reg[i] <= succ_line_reg[i-1];
            end
        end
    end

    // heading of the summed unit vectors
    logic            c_valid, c_zero;
    logic [AccW-1:0] c_acc;

    vbh_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (ua_valid && ub_valid),
        .ax        (ua_x),
        .az        (ua_z),
        .bx        (ub_x),
        .bz        (ub_z),
        .out_valid (c_valid),
        .out_zero  (c_zero),
        .out_acc   (c_acc)
    );

    // zero sum reads as heading zero; chain end turns by half; round to 16 bits
    logic [AccW-1:0] acc_base, acc_turn, acc_round;

    assign acc_base  = c_zero ? '0 : c_acc;
    assign acc_turn  = succ_line_reg[SuccLat-1] ? acc_base : acc_base + HalfTurn;
    assign acc_round = acc_turn + RoundAdd;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= c_valid;
        end
        if (en) begin
            m_heading_reg <= acc_round[AccW-1 -: AngleW];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_heading_angle = m_heading_reg;

endmodule

[hdl/vbh_unit.sv]
// one normalizing lane: squares, pipelined square root, two pipelined dividers
module vbh_unit
    import vbh_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [DiffW-1:0] dx,
    input  logic signed [DiffW-1:0] dz,
    output logic                    out_valid,
    output logic signed [UnitW-1:0] ux,
    output logic signed [UnitW-1:0] uz
);

    logic [DiffW-1:0] ax, az;
    logic [2*DiffW-1:0] px, pz;
    vbh_flags_t fl_in;

    assign ax = dx[DiffW-1] ? DiffW'(-dx) : DiffW'(dx);
    assign az = dz[DiffW-1] ? DiffW'(-dz) : DiffW'(dz);
    assign px = ax * ax;
    assign pz = az * az;
    assign fl_in = '{neg_x: dx[DiffW-1], neg_z: dz[DiffW-1], zero: (dx == '0) && (dz == '0)};

    // squares
    logic             a_valid_reg;
    logic [SqW-1:0]   a_sqx_reg, a_sqz_reg;
    logic [DiffW-1:0] a_ax_reg, a_az_reg;
    vbh_flags_t       a_fl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
        end
        if (en) begin
            a_sqx_reg <= px[SqW-1:0];
            a_sqz_reg <= pz[SqW-1:0];
            a_ax_reg  <= ax;
            a_az_reg  <= az;
            a_fl_reg  <= fl_in;
        end
    end

    // square root pipeline, one result bit per stage
    logic             s_valid_reg [0:SqrtSteps];
    logic [RadW-1:0]  s_n_reg     [0:SqrtSteps];
    logic [RadW-1:0]  s_r_reg     [0:SqrtSteps];
    logic [DiffW-1:0] s_ax_reg    [0:SqrtSteps];
    logic [DiffW-1:0] s_az_reg    [0:SqrtSteps];
    vbh_flags_t       s_fl_reg    [0:SqrtSteps];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_valid_reg[0] <= 1'b0;
        end else if (en) begin
            s_valid_reg[0] <= a_valid_reg;
        end
        if (en) begin
            s_n_reg[0]  <= RadW'({(SqW+1)'(a_sqx_reg) + (SqW+1)'(a_sqz_reg), 14'b0});
            s_r_reg[0]  <= '0;
            s_ax_reg[0] <= a_ax_reg;
            s_az_reg[0] <= a_az_reg;
            s_fl_reg[0] <= a_fl_reg;
        end
    end

    for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
        localparam logic [RadW-1:0] Bit = RadW'(1) << (RadW - 2 - 2 * k);
        logic [RadW-1:0] trial, n_next, r_next;
        always_comb begin
            trial = s_r_reg[k] + Bit;
            if (s_n_reg[k] >= trial) begin
                n_next = s_n_reg[k] - trial;
                r_next = (s_r_reg[k] >> 1) + Bit;
            end else begin
                n_next = s_n_reg[k];
                r_next = s_r_reg[k] >> 1;
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                s_valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                s_valid_reg[k+1] <= s_valid_reg[k];
            end
            if (en) begin
                s_n_reg[k+1]  <= n_next;
                s_r_reg[k+1]  <= r_next;
                s_ax_reg[k+1] <= s_ax_reg[k];
                s_az_reg[k+1] <= s_az_reg[k];
                s_fl_reg[k+1] <= s_fl_reg[k];
            end
        end
    end

    // rounded numerators and divider pipeline
    logic             d_valid_reg [0:DivSteps];
    logic [NumW-1:0]  d_remx_reg  [0:DivSteps];
    logic [NumW-1:0]  d_remz_reg  [0:DivSteps];
    logic [QuoW-1:0]  d_qx_reg    [0:DivSteps];
    logic [QuoW-1:0]  d_qz_reg    [0:DivSteps];
    logic [RootW-1:0] d_len_reg   [0:DivSteps];
    vbh_flags_t       d_fl_reg    [0:DivSteps];

    logic [RootW-1:0] len_root;
    assign len_root = s_r_reg[SqrtSteps][RootW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg[0] <= 1'b0;
        end else if (en) begin
            d_valid_reg[0] <= s_valid_reg[SqrtSteps];
        end
        if (en) begin
            d_remx_reg[0] <= (NumW'(s_ax_reg[SqrtSteps]) << 23) + NumW'(len_root >> 1);
            d_remz_reg[0] <= (NumW'(s_az_reg[SqrtSteps]) << 23) + NumW'(len_root >> 1);
            d_qx_reg[0]   <= '0;
            d_qz_reg[0]   <= '0;
            d_len_reg[0]  <= len_root;
            d_fl_reg[0]   <= s_fl_reg[SqrtSteps];
        end
    end

    for (genvar k = 0; k < DivSteps; k++) begin : g_div
        logic [NumW+1:0] dvs;
        logic            gex, gez;
        assign dvs = (NumW+2)'(d_len_reg[k]) << (DivSteps - 1 - k);
        assign gex = (NumW+2)'(d_remx_reg[k]) >= dvs;
        assign gez = (NumW+2)'(d_remz_reg[k]) >= dvs;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                d_valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                d_valid_reg[k+1] <= d_valid_reg[k];
            end
            if (en) begin
                d_remx_reg[k+1] <= gex ? NumW'((NumW+2)'(d_remx_reg[k]) - dvs)
                                       : d_remx_reg[k];
                d_remz_reg[k+1] <= gez ? NumW'((NumW+2)'(d_remz_reg[k]) - dvs)
                                       : d_remz_reg[k];
                d_qx_reg[k+1]   <= {d_qx_reg[k][QuoW-2:0], gex};
                d_qz_reg[k+1]   <= {d_qz_reg[k][QuoW-2:0], gez};
                d_len_reg[k+1]  <= d_len_reg[k];
                d_fl_reg[k+1]   <= d_fl_reg[k];
            end
        end
    end

    // clamp, sign and zero vector
    logic [QuoW-1:0] cqx, cqz;
    vbh_flags_t      fl_out;
    logic            o_valid_reg;
    logic signed [UnitW-1:0] o_ux_reg, o_uz_reg;

    assign fl_out = d_fl_reg[DivSteps];
    assign cqx = (d_qx_reg[DivSteps] > UnitOne) ? UnitOne : d_qx_reg[DivSteps];
    assign cqz = (d_qz_reg[DivSteps] > UnitOne) ? UnitOne : d_qz_reg[DivSteps];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (en) begin
            o_valid_reg <= d_valid_reg[DivSteps];
        end
        if (en) begin
            if (fl_out.zero) begin
                o_ux_reg <= '0;
                o_uz_reg <= '0;
            end else begin
                o_ux_reg <= fl_out.neg_x ? -$signed(UnitW'(cqx)) : $signed(UnitW'(cqx));
                o_uz_reg <= fl_out.neg_z ? -$signed(UnitW'(cqz)) : $signed(UnitW'(cqz));
            end
        end
    end

    assign out_valid = o_valid_reg;
    assign ux = o_ux_reg;
    assign uz = o_uz_reg;

endmodule

[hdl/vbh_cordic.sv]
// vector sum and pipelined vectoring cordic giving a 32-bit heading
module vbh_cordic
    import vbh_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [UnitW-1:0] ax,
    input  logic signed [UnitW-1:0] az,
    input  logic signed [UnitW-1:0] bx,
    input  logic signed [UnitW-1:0] bz,
    output logic                    out_valid,
    output logic                    out_zero,
    output logic [AccW-1:0]         out_acc
);

    logic signed [SumW-1:0]  sx, sz;
    logic signed [CordW-1:0] x0, z0;

    assign sx = SumW'(ax) + SumW'(bx);
    assign sz = SumW'(az) + SumW'(bz);
    assign x0 = CordW'(sx) <<< 8;
    assign z0 = CordW'(sz) <<< 8;

    logic                    c_valid_reg [0:CordicN];
    logic                    c_zero_reg  [0:CordicN];
    logic signed [CordW-1:0] c_x_reg     [0:CordicN];
    logic signed [CordW-1:0] c_z_reg     [0:CordicN];
    logic [AccW-1:0]         c_acc_reg   [0:CordicN];

    // half turn first when z is negative
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg[0] <= 1'b0;
        end else if (en) begin
            c_valid_reg[0] <= in_valid;
        end
        if (en) begin
            c_zero_reg[0] <= (sx == '0) && (sz == '0);
            if (sz < 0) begin
                c_x_reg[0]   <= -x0;
                c_z_reg[0]   <= -z0;
                c_acc_reg[0] <= HalfTurn;
            end else begin
                c_x_reg[0]   <= x0;
                c_z_reg[0]   <= z0;
                c_acc_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CordicN; i++) begin : g_rot
        localparam logic [AccW-1:0] Ang = atan_entry(i);
        logic signed [CordW-1:0] shx, shz;
        assign shx = c_x_reg[i] >>> i;
        assign shz = c_z_reg[i] >>> i;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                c_valid_reg[i+1] <= 1'b0;
            end else if (en) begin
                c_valid_reg[i+1] <= c_valid_reg[i];
            end
            if (en) begin
                c_zero_reg[i+1] <= c_zero_reg[i];
                if (c_x_reg[i] > 0) begin
                    c_z_reg[i+1]   <= c_z_reg[i] + shx;
                    c_x_reg[i+1]   <= c_x_reg[i] - shz;
                    c_acc_reg[i+1] <= c_acc_reg[i] + Ang;
                end else begin
                    c_z_reg[i+1]   <= c_z_reg[i] - shx;
                    c_x_reg[i+1]   <= c_x_reg[i] + shz;
                    c_acc_reg[i+1] <= c_acc_reg[i] - Ang;
                end
            end
        end
    end

    assign out_valid = c_valid_reg[CordicN];
    assign out_zero  = c_zero_reg[CordicN];
    assign out_acc   = c_acc_reg[CordicN];

endmodule
